[hw/rtl/aar_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// aar_pkg: shared types and constants of the annealing accept/reject unit
// Holds the sequencer states, divider control, table fill phases, register
// indexes and the Q62 constants used to build the exponential table.
// ---------------------------------------------------------------------------
package aar_pkg;

   // default depth of the exp(-q) probability table
   localparam int PROB_TABLE_DEPTH = 4096;

   // shift-subtract divider: 40-bit dividend, iteration counter
   localparam int DIV_W     = 40;
   localparam int DIV_CNT_W = 6;
   localparam int DIVISOR_W = 32;
   localparam logic [DIV_CNT_W-1:0] MOD_ITERS = DIV_CNT_W'(32);
   localparam logic [DIV_CNT_W-1:0] DIV_ITERS = DIV_CNT_W'(40);

   localparam int COST_W = 32;
   localparam int TEMP_W = 32;
   localparam int PROB_W = 16;
   localparam int STEP_W = 31;

   localparam logic [PROB_W-1:0] PROB_MAX = '1;

   // configuration registers
   localparam logic [31:0]       RESET_PERIOD_INIT = 32'hFFFF_FFFF;
   localparam logic [STEP_W-1:0] LAST_ITER_INIT    = STEP_W'(1000);

   typedef enum logic [0:0] {
      CSR_RESET_PERIOD   = 1'b0,
      CSR_LAST_ITERATION = 1'b1
   } csr_index_type;

   // main sequencer
   typedef enum logic [2:0] {
      ST_FILL,
      ST_IDLE,
      ST_MOD_START,
      ST_MOD_WAIT,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_TABLE_RD,
      ST_FINISH
   } state_type;

   // divider start command
   typedef struct packed {
      logic                 start;
      logic [DIV_CNT_W-1:0] iters;
   } div_ctl_type;

   // table fill: four partial products, final add, write and advance
   typedef enum logic [2:0] {
      PH_LL,
      PH_LH,
      PH_HL,
      PH_HH,
      PH_ADD,
      PH_STEP
   } fill_phase_type;

   localparam logic [63:0] Q62_ONE = 64'h4000_0000_0000_0000;

   // exp(-1/256) in Q62 from its alternating series, evaluated at elaboration
   function automatic logic [63:0] exp_ratio_q62();
      logic [63:0] term;
      logic [63:0] ratio;
      term  = Q62_ONE;
      ratio = Q62_ONE;
      for (int n = 1; n < 20; n++) begin
         term = (term >> 8) / 64'(n);
         if ((n % 2) == 1) begin
            ratio = ratio - term;
         end else begin
            ratio = ratio + term;
         end
      end
      return ratio;
   endfunction

   localparam logic [63:0] EXP_RATIO = exp_ratio_q62();

endpackage
`default_nettype wire

[hw/rtl/aar_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// aar_ram: generic single-port-write, single-port-read memory
// One write and one read per cycle; the read data is registered.
// ---------------------------------------------------------------------------
module aar_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[hw/rtl/aar_divider.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// aar_divider: shared restoring shift-subtract divider
// One quotient bit per cycle over a left-aligned 40-bit dividend; the
// dividend register shifts out at the top and collects quotient bits.
// ---------------------------------------------------------------------------
module aar_divider (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire aar_pkg::div_ctl_type           ctl,
   input  wire logic [aar_pkg::DIV_W-1:0]      dividend,
   input  wire logic [aar_pkg::DIVISOR_W-1:0]  divisor,
   output logic      [aar_pkg::DIV_W-1:0]      quotient,
   output logic      [aar_pkg::DIVISOR_W-1:0]  remainder,
   output logic                                busy
);

   localparam int DW = aar_pkg::DIVISOR_W;
   localparam int NW = aar_pkg::DIV_W;

   logic [NW-1:0]                 sh_ff, sh_in;
   logic [DW-1:0]                 rem_ff, rem_in;
   logic [DW-1:0]                 dsr_ff, dsr_in;
   logic [aar_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   logic [DW+1:0]                 trial;
   logic                          ge;

   // trial subtract of the shifted partial remainder
   assign trial = {1'b0, rem_ff, sh_ff[NW-1]} - {2'b00, dsr_ff};
   assign ge    = ~trial[DW+1];

   // load on start, otherwise one quotient bit per cycle
   always_comb begin
      sh_in   = sh_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (ctl.start) begin
         sh_in   = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = ctl.iters;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         sh_in   = {sh_ff[NW-2:0], ge};
         rem_in  = ge ? trial[DW-1:0] : {rem_ff[DW-2:0], sh_ff[NW-1]};
         cnt_in  = cnt_ff - 1'b1;
         busy_in = (cnt_ff != aar_pkg::DIV_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      sh_ff  <= sh_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign quotient  = sh_ff;
   assign remainder = rem_ff;
   assign busy      = busy_ff;

endmodule
`default_nettype wire

[hw/rtl/aar_table_fill.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// aar_table_fill: builds the exp(-q/256) probability table after reset
// Repeated Q62 multiplication by exp(-1/256) through one 32x32 multiplier,
// four partial products per entry; each entry is rounded to Q0.16.
// ---------------------------------------------------------------------------
module aar_table_fill #(
   parameter int DEPTH = aar_pkg::PROB_TABLE_DEPTH
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   output logic                            wr_en,
   output logic [$clog2(DEPTH)-1:0]        wr_addr,
   output logic [aar_pkg::PROB_W-1:0]      wr_data,
   output logic                            done
);

   localparam int AW  = $clog2(DEPTH);
   localparam int VW  = 63;
   localparam int ACW = 126;
   localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
   localparam logic [31:0]   R_LO     = aar_pkg::EXP_RATIO[31:0];
   localparam logic [31:0]   R_HI     = aar_pkg::EXP_RATIO[63:32];

   aar_pkg::fill_phase_type phase_ff, phase_in;
   logic [VW-1:0]   v_ff, v_in;
   logic [ACW-1:0]  acc_ff, acc_in;
   logic [63:0]     prod_ff, prod_in;
   logic [AW-1:0]   idx_ff, idx_in;
   logic            done_ff, done_in;
   logic [31:0]     op_a;
   logic [31:0]     op_b;
   logic [63:0]     rnd_sum;
   logic [17:0]     entry;

   // operand select for the shared multiplier
   always_comb begin
      op_a = v_ff[31:0];
      op_b = R_LO;
      case (phase_ff)
         aar_pkg::PH_LH: begin
            op_a = v_ff[31:0];
            op_b = R_HI;
         end
         aar_pkg::PH_HL: begin
            op_a = {1'b0, v_ff[VW-1:32]};
            op_b = R_LO;
         end
         aar_pkg::PH_HH: begin
            op_a = {1'b0, v_ff[VW-1:32]};
            op_b = R_HI;
         end
         default: begin
            op_a = v_ff[31:0];
            op_b = R_LO;
         end
      endcase
   end

   // rounding of the current Q62 value to Q0.16, capped
   assign rnd_sum = {1'b0, v_ff} + 64'h0000_2000_0000_0000;
   assign entry   = rnd_sum[63:46];

   always_comb begin
      phase_in = phase_ff;
      v_in     = v_ff;
      acc_in   = acc_ff;
      idx_in   = idx_ff;
      done_in  = done_ff;
      prod_in  = op_a * op_b;
      wr_en    = 1'b0;
      if (!done_ff) begin
         unique case (phase_ff)
            aar_pkg::PH_LL: begin
               phase_in = aar_pkg::PH_LH;
            end
            aar_pkg::PH_LH: begin
               acc_in   = ACW'(prod_ff);
               phase_in = aar_pkg::PH_HL;
            end
            aar_pkg::PH_HL: begin
               acc_in   = acc_ff + (ACW'(prod_ff) << 32);
               phase_in = aar_pkg::PH_HH;
            end
            aar_pkg::PH_HH: begin
               acc_in   = acc_ff + (ACW'(prod_ff) << 32);
               phase_in = aar_pkg::PH_ADD;
            end
            aar_pkg::PH_ADD: begin
               acc_in   = acc_ff + (ACW'(prod_ff) << 64);
               phase_in = aar_pkg::PH_STEP;
            end
            aar_pkg::PH_STEP: begin
               wr_en    = 1'b1;
               v_in     = acc_ff[ACW-2:62];
               idx_in   = idx_ff + 1'b1;
               done_in  = (idx_ff == LAST_IDX);
               phase_in = aar_pkg::PH_LL;
            end
            default: begin
               phase_in = aar_pkg::PH_LL;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= aar_pkg::PH_LL;
         v_ff     <= aar_pkg::Q62_ONE[VW-1:0];
         idx_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         v_ff     <= v_in;
         idx_ff   <= idx_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
   end

   assign wr_addr = idx_ff;
   assign wr_data = (entry > 18'(aar_pkg::PROB_MAX)) ? aar_pkg::PROB_MAX
                                                    : entry[aar_pkg::PROB_W-1:0];
   assign done    = done_ff;

endmodule
`default_nettype wire

[hw/rtl/annealing_accept_reject_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// annealing_accept_reject_unit: Metropolis accept/reject with best tracking
// Decides per annealing step whether a proposed cost is taken, keeps current
// and best cost, and resets the chain to the best cost on schedule.
// ---------------------------------------------------------------------------
// Usage:
//  - req_* carries one request (proposed cost, temperature, random draw,
//    step number); it is taken when req_valid is high and req_stall low.
//  - rsp_* carries one result per request under the same valid/stall rule.
//  - csr_* writes reset_period (index 0) and last_iteration (index 1).
// Timing:
//  - after reset the exp table is built; req_stall stays high meanwhile.
//  - one request at a time through a shared shift-subtract divider: the
//    period remainder, then the Q32.8 quotient (a Q4.8 table index by
//    default), then the table read and the result; the next request is taken
//    once the result is written; the first step skips the divider and table.
//  - the result sits in an output register; a stalled result holds, and
//    the next request is taken meanwhile but not finished until it drains.
// ---------------------------------------------------------------------------
module annealing_accept_reject_unit #(
   parameter int PROB_TABLE_DEPTH = aar_pkg::PROB_TABLE_DEPTH
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // request channel
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [31:0] req_proposed_cost,
   input  wire logic [31:0]        req_temperature,
   input  wire logic [15:0]        req_random_draw,
   input  wire logic [30:0]        req_step_number,
   // result channel
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_accepted,
   output logic                    rsp_improved_best,
   output logic                    rsp_reset_done,
   output logic signed [31:0]      rsp_current_cost_out,
   output logic signed [31:0]      rsp_best_cost_out,
   output logic [15:0]             rsp_accept_probability,
   // configuration
   input  wire logic               csr_we,
   input  wire logic [0:0]         csr_index,
   input  wire logic [31:0]        csr_wdata
);

   localparam int AW = $clog2(PROB_TABLE_DEPTH);
   localparam int NW = aar_pkg::DIV_W;
   localparam int SW = aar_pkg::STEP_W;
   localparam int PW = aar_pkg::PROB_W;

   aar_pkg::state_type state_ff, state_in;

   // configuration registers
   logic [31:0]              reset_period_ff;
   logic [SW-1:0]            last_iteration_ff;

   // request under work
   logic signed [31:0]       prop_ff, prop_in;
   logic [31:0]              temp_ff, temp_in;
   logic [PW-1:0]            rnd_ff, rnd_in;
   logic [SW-1:0]            step_ff, step_in;
   logic [32:0]              diff_ff, diff_in;
   logic [PW-1:0]            prob_ff, prob_in;
   logic                     mod_zero_ff, mod_zero_in;

   // chain state
   logic signed [31:0]       current_cost_ff, current_cost_in;
   logic signed [31:0]       best_cost_ff, best_cost_in;

   // result register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     acc_ff, acc_in;
   logic                     impr_ff, impr_in;
   logic                     rst_ff, rst_in;
   logic signed [31:0]       cur_out_ff, cur_out_in;
   logic signed [31:0]       best_out_ff, best_out_in;
   logic [PW-1:0]            prob_out_ff, prob_out_in;

   // shared divider and table
   aar_pkg::div_ctl_type     div_ctl;
   logic [NW-1:0]            div_dividend;
   logic [31:0]              div_divisor;
   logic [NW-1:0]            div_quotient;
   logic [31:0]              div_remainder;
   logic                     div_busy;
   logic                     fill_wr_en;
   logic [AW-1:0]            fill_wr_addr;
   logic [PW-1:0]            fill_wr_data;
   logic                     fill_done;
   logic [PW-1:0]            table_data;

   logic                     req_fire;
   logic                     rsp_free;
   logic                     diff_pos;
   logic                     need_div;
   logic                     q_over;
   logic [31:0]              step_m1;
   logic                     accept_now;
   logic                     impr_now;
   logic                     period_hit;
   logic                     rst_now;
   logic signed [31:0]       cur_after;
   logic signed [31:0]       best_after;
   logic [PW-1:0]            prob_eff;

   assign req_fire = req_valid && !req_stall;
   assign req_stall = (state_ff != aar_pkg::ST_IDLE);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // decode of the request under work
   assign diff_pos = !diff_ff[32] && (diff_ff[31:0] != 32'd0);
   assign need_div = diff_pos && (temp_ff != 32'd0);
   assign q_over   = (div_quotient >= NW'(PROB_TABLE_DEPTH));
   assign step_m1  = {1'b0, step_ff} - 32'd1;

   // divider command and operands
   always_comb begin
      div_ctl.start = 1'b0;
      div_ctl.iters = aar_pkg::MOD_ITERS;
      div_dividend  = {step_m1, 8'h00};
      div_divisor   = reset_period_ff;
      if (state_ff == aar_pkg::ST_MOD_START) begin
         div_ctl.start = (reset_period_ff != 32'd0);
      end else if (state_ff == aar_pkg::ST_DIV_START) begin
         div_ctl.start = 1'b1;
         div_ctl.iters = aar_pkg::DIV_ITERS;
         div_dividend  = {diff_ff[31:0], 8'h00};
         div_divisor   = temp_ff;
      end
   end

   // decision, best tracking and reset to best
   always_comb begin
      prob_eff   = !diff_pos ? aar_pkg::PROB_MAX
                 : (temp_ff == 32'd0) ? '0 : prob_ff;
      accept_now = !diff_pos || (rnd_ff < prob_eff);
      impr_now   = (prop_ff < best_cost_ff);
      cur_after  = accept_now ? prop_ff : current_cost_ff;
      best_after = impr_now ? prop_ff : best_cost_ff;
      period_hit = mod_zero_ff && ({1'b0, step_ff} != ({1'b0, last_iteration_ff} + 32'd1));
      rst_now    = (step_ff == last_iteration_ff) || period_hit;
   end

   // sequencer: next state and datapath updates
   always_comb begin
      state_in        = state_ff;
      prop_in         = prop_ff;
      temp_in         = temp_ff;
      rnd_in          = rnd_ff;
      step_in         = step_ff;
      diff_in         = diff_ff;
      prob_in         = prob_ff;
      mod_zero_in     = mod_zero_ff;
      current_cost_in = current_cost_ff;
      best_cost_in    = best_cost_ff;
      acc_in          = acc_ff;
      impr_in         = impr_ff;
      rst_in          = rst_ff;
      cur_out_in      = cur_out_ff;
      best_out_in     = best_out_ff;
      prob_out_in     = prob_out_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         aar_pkg::ST_FILL: begin
            if (fill_done) begin
               state_in = aar_pkg::ST_IDLE;
            end
         end
         aar_pkg::ST_IDLE: begin
            if (req_fire) begin
               prop_in  = req_proposed_cost;
               temp_in  = req_temperature;
               rnd_in   = req_random_draw;
               step_in  = req_step_number;
               diff_in  = {req_proposed_cost[31], req_proposed_cost}
                        - {current_cost_ff[31], current_cost_ff};
               prob_in  = aar_pkg::PROB_MAX;
               state_in = (req_step_number == SW'(1)) ? aar_pkg::ST_FINISH
                                                      : aar_pkg::ST_MOD_START;
            end
         end
         aar_pkg::ST_MOD_START: begin
            if (reset_period_ff == 32'd0) begin
               mod_zero_in = 1'b0;
               state_in    = need_div ? aar_pkg::ST_DIV_START : aar_pkg::ST_FINISH;
            end else begin
               state_in = aar_pkg::ST_MOD_WAIT;
            end
         end
         aar_pkg::ST_MOD_WAIT: begin
            if (!div_busy) begin
               mod_zero_in = (div_remainder == 32'd0);
               state_in    = need_div ? aar_pkg::ST_DIV_START : aar_pkg::ST_FINISH;
            end
         end
         aar_pkg::ST_DIV_START: begin
            state_in = aar_pkg::ST_DIV_WAIT;
         end
         aar_pkg::ST_DIV_WAIT: begin
            if (!div_busy) begin
               if (q_over) begin
                  prob_in  = '0;
                  state_in = aar_pkg::ST_FINISH;
               end else begin
                  state_in = aar_pkg::ST_TABLE_RD;
               end
            end
         end
         aar_pkg::ST_TABLE_RD: begin
            // the quotient was stable last cycle, so the table data is valid now
            prob_in  = table_data;
            state_in = aar_pkg::ST_FINISH;
         end
         aar_pkg::ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               state_in     = aar_pkg::ST_IDLE;
               if (step_ff == SW'(1)) begin
                  current_cost_in = prop_ff;
                  best_cost_in    = prop_ff;
                  acc_in          = 1'b1;
                  impr_in         = 1'b1;
                  rst_in          = 1'b0;
                  cur_out_in      = prop_ff;
                  best_out_in     = prop_ff;
                  prob_out_in     = aar_pkg::PROB_MAX;
               end else begin
                  current_cost_in = rst_now ? best_after : cur_after;
                  best_cost_in    = best_after;
                  acc_in          = accept_now;
                  impr_in         = impr_now;
                  rst_in          = rst_now;
                  cur_out_in      = rst_now ? best_after : cur_after;
                  best_out_in     = best_after;
                  prob_out_in     = prob_eff;
               end
            end
         end
         default: begin
            state_in = aar_pkg::ST_IDLE;
         end
      endcase
   end

   // control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= aar_pkg::ST_FILL;
         rsp_valid_ff      <= 1'b0;
         current_cost_ff   <= '0;
         best_cost_ff      <= '0;
         reset_period_ff   <= aar_pkg::RESET_PERIOD_INIT;
         last_iteration_ff <= aar_pkg::LAST_ITER_INIT;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         current_cost_ff <= current_cost_in;
         best_cost_ff    <= best_cost_in;
         if (csr_we) begin
            unique case (csr_index)
               aar_pkg::CSR_RESET_PERIOD: begin
                  reset_period_ff <= csr_wdata;
               end
               aar_pkg::CSR_LAST_ITERATION: begin
                  last_iteration_ff <= csr_wdata[SW-1:0];
               end
               default: begin
                  reset_period_ff <= reset_period_ff;
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      prop_ff     <= prop_in;
      temp_ff     <= temp_in;
      rnd_ff      <= rnd_in;
      step_ff     <= step_in;
      diff_ff     <= diff_in;
      prob_ff     <= prob_in;
      mod_zero_ff <= mod_zero_in;
      acc_ff      <= acc_in;
      impr_ff     <= impr_in;
      rst_ff      <= rst_in;
      cur_out_ff  <= cur_out_in;
      best_out_ff <= best_out_in;
      prob_out_ff <= prob_out_in;
   end

   aar_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .ctl       (div_ctl),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .quotient  (div_quotient),
      .remainder (div_remainder),
      .busy      (div_busy)
   );

   aar_table_fill #(
      .DEPTH (PROB_TABLE_DEPTH)
   ) u_table_fill (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (fill_wr_en),
      .wr_addr (fill_wr_addr),
      .wr_data (fill_wr_data),
      .done    (fill_done)
   );

   aar_ram #(
      .WIDTH (PW),
      .DEPTH (PROB_TABLE_DEPTH)
   ) u_prob_table (
      .clock   (clock),
      .wr_en   (fill_wr_en),
      .wr_addr (fill_wr_addr),
      .wr_data (fill_wr_data),
      .rd_addr (div_quotient[AW-1:0]),
      .rd_data (table_data)
   );

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_accepted           = acc_ff;
   assign rsp_improved_best      = impr_ff;
   assign rsp_reset_done         = rst_ff;
   assign rsp_current_cost_out   = cur_out_ff;
   assign rsp_best_cost_out      = best_out_ff;
   assign rsp_accept_probability = prob_out_ff;

   // best cost never rises above the current cost
   assert property (@(posedge clock) disable iff (reset)
      best_cost_ff <= current_cost_ff)
      else $error("best cost above current cost");

   // divider runs only while the sequencer waits on it
   assert property (@(posedge clock) disable iff (reset)
      div_busy |-> (state_ff == aar_pkg::ST_MOD_WAIT || state_ff == aar_pkg::ST_DIV_WAIT))
      else $error("divider busy outside a wait state");

   // a new result only comes out of the finish state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == aar_pkg::ST_FINISH)
      else $error("result raised outside finish");

   // no request is worked on before the table is complete
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != aar_pkg::ST_FILL) |-> fill_done)
      else $error("table incomplete after fill");

endmodule
`default_nettype wire
